// ===== hw/rtl/cht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Field widths, operation and status codes, default table sizes.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int BUCKET_COUNT_DEF = 20;
  localparam int ENTRY_COUNT_DEF  = 64;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5
  } status_t;

endpackage

// ===== hw/rtl/cht_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_ifs: request and response channels of the chained hash table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface cht_req_if;
  logic                        valid;
  logic                        ready;
  logic [cht_pkg::OP_W-1:0]    operation;
  logic [cht_pkg::KEY_W-1:0]   key;
  logic [cht_pkg::VALUE_W-1:0] value;

  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface cht_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cht_pkg::STATUS_W-1:0] status;
  logic [cht_pkg::VALUE_W-1:0]  found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

// ===== hw/rtl/cht_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_mod: key modulo bucket count
// Reciprocal multiply for the quotient, then multiply back and subtract.
// The product is registered on start and the remainder on prod_vld; done follows prod_vld.
// ----------------------------------------------------------------------------
module cht_mod #(
  parameter int BUCKET_COUNT = cht_pkg::BUCKET_COUNT_DEF,
  localparam int RW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cht_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [RW-1:0]             bucket
);

  localparam int KW    = cht_pkg::KEY_W;
  localparam int SHIFT = KW + $clog2(BUCKET_COUNT);
  localparam int MW    = KW + 1;
  localparam int PW    = KW + MW;
  // ceil(2^SHIFT / BUCKET_COUNT): the rounding error stays below
  // 2^(SHIFT-KW), so the quotient is exact for every key
  localparam longint RECIP_VAL =
    ((longint'(1) << SHIFT) + longint'(BUCKET_COUNT) - longint'(1)) /
    longint'(BUCKET_COUNT);
  localparam logic [MW-1:0] RECIP   = MW'(RECIP_VAL);
  localparam logic [KW-1:0] DIVISOR = KW'(BUCKET_COUNT);

  logic [KW-1:0] key_q;
  logic [PW-1:0] prod;
  logic          prod_vld;
  logic [KW-1:0] quot;
  logic [KW-1:0] back;
  logic [KW-1:0] diff;
  logic [RW-1:0] rem;

  assign quot = KW'(prod >> SHIFT);
  assign back = quot * DIVISOR;
  assign diff = key_q - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      prod_vld <= start;
      done     <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
      prod  <= PW'(key) * PW'(RECIP);
    end
    if (prod_vld) begin
      rem <= diff[RW-1:0];
    end
  end

  assign bucket = rem;

endmodule

// ===== hw/rtl/cht_head_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_head_mem: bucket head memory
// One read, one write port; registered read. Valid bits make unwritten
// buckets read as the null index.
// ----------------------------------------------------------------------------
module cht_head_mem #(
  parameter int BUCKET_COUNT = cht_pkg::BUCKET_COUNT_DEF,
  parameter int ENTRY_COUNT  = cht_pkg::ENTRY_COUNT_DEF,
  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1,
  localparam int IW = $clog2(ENTRY_COUNT + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [BW-1:0] rd_addr,
  output logic [IW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [BW-1:0] wr_addr,
  input  logic [IW-1:0] wr_data
);

  localparam logic [IW-1:0] NIL = IW'(ENTRY_COUNT);

  logic [IW-1:0]           mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] vld;
  logic [IW-1:0]           data_q;
  logic                    vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
      vld_q  <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = vld_q ? data_q : NIL;

endmodule

// ===== hw/rtl/cht_entry_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_entry_mem: entry pool memory
// Word is {key, value, link}; one read, one write port; registered read.
// ----------------------------------------------------------------------------
module cht_entry_mem #(
  parameter int DEPTH = cht_pkg::ENTRY_COUNT_DEF,
  parameter int DW    = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/chained_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table: key/value table with separate chaining
//
// Requests arrive on req (operation, key, value); one response per request
// leaves on rsp (status, found_value). Operations: insert or update, lookup,
// remove. The bucket is key modulo BUCKET_COUNT; each bucket heads a linked
// chain of entries drawn from a pool of ENTRY_COUNT entries.
//
// One request is processed at a time. After acceptance the key passes the
// modulo unit (reciprocal multiply, then multiply back and subtract), then
// the bucket head is read, then the entry memory is read once per chain
// step, and finally the response register is loaded. An append adds the
// S_ALLOC and S_LINK states and a remove adds S_LINK; the unused opcode
// skips the head read and the walk. The chain walk through the single entry
// memory read port sets the rate.
//
// Reset (rst, synchronous) empties every bucket and rebuilds the free pool;
// it takes effect at once, no clearing pass. The response sits in an output
// register: while rsp is stalled a new request is still accepted and
// processed, and only its own response waits for the register to free up.
// ----------------------------------------------------------------------------
module chained_hash_table #(
  parameter int BUCKET_COUNT = cht_pkg::BUCKET_COUNT_DEF,
  parameter int ENTRY_COUNT  = cht_pkg::ENTRY_COUNT_DEF
) (
  input logic      clk,
  input logic      rst,
  cht_req_if.sink  req,
  cht_rsp_if.source rsp
);

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int IW = $clog2(ENTRY_COUNT + 1);
  localparam int AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int KW = cht_pkg::KEY_W;
  localparam int VW = cht_pkg::VALUE_W;
  localparam int EW = KW + VW + IW;
  localparam logic [IW-1:0] NIL = IW'(ENTRY_COUNT);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_HEAD  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_ALLOC = 7'b0010000,
    S_LINK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  // request being processed
  logic [cht_pkg::OP_W-1:0] op_q;
  logic [KW-1:0]            key_q;
  logic [VW-1:0]            val_q;
  logic [BW-1:0]            bucket;

  // walk pointers: cur is the entry whose word is coming out of memory;
  // prev tracks the predecessor (and ends up as the tail on a miss)
  logic [IW-1:0] cur;
  logic [IW-1:0] prev;
  logic [KW-1:0] prev_key;
  logic [VW-1:0] prev_val;

  // free pool: recycled entries form a stack at free_head; entries at and
  // above fill were never handed out and implicitly link to the next index
  logic [IW-1:0] free_head;
  logic [IW-1:0] fill;

  cht_pkg::status_t res_status;
  logic [VW-1:0]    res_value;

  logic             out_valid;
  cht_pkg::status_t out_status;
  logic [VW-1:0]    out_value;

  // modulo unit
  logic          mod_start;
  logic          mod_done;
  logic [BW-1:0] mod_bucket;

  // memory ports
  logic          head_rd_en;
  logic [IW-1:0] head_rd_data;
  logic          head_wr_en;
  logic [IW-1:0] head_wr_data;
  logic          ent_rd_en;
  logic [AW-1:0] ent_rd_addr;
  logic [EW-1:0] ent_rd_data;
  logic          ent_wr_en;
  logic [AW-1:0] ent_wr_addr;
  logic [EW-1:0] ent_wr_data;

  logic [KW-1:0] ent_key;
  logic [VW-1:0] ent_val;
  logic [IW-1:0] ent_link;
  logic          hit;
  logic          link_end;
  logic          head_empty;
  logic          pool_empty;
  logic          miss_now;

  assign ent_key  = ent_rd_data[EW-1 -: KW];
  assign ent_val  = ent_rd_data[IW+VW-1 -: VW];
  assign ent_link = ent_rd_data[IW-1:0];

  assign hit        = (ent_key == key_q);
  assign link_end   = (ent_link >= NIL);
  assign head_empty = (head_rd_data >= NIL);
  assign pool_empty = (free_head >= NIL);

  // end of chain reached without a match (empty bucket or tail passed)
  assign miss_now = ((state == S_HEAD) && head_empty) ||
                    ((state == S_WALK) && !hit && link_end);

  assign req.ready = (state == S_IDLE);
  assign mod_start = req.valid && (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_value = out_value;

  cht_mod #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   (req.key),
    .done  (mod_done),
    .bucket(mod_bucket)
  );

  cht_head_mem #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_head_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (head_rd_en),
    .rd_addr(mod_bucket),
    .rd_data(head_rd_data),
    .wr_en  (head_wr_en),
    .wr_addr(bucket),
    .wr_data(head_wr_data)
  );

  cht_entry_mem #(
    .DEPTH(ENTRY_COUNT),
    .DW   (EW)
  ) u_entry_mem (
    .clk    (clk),
    .rd_en  (ent_rd_en),
    .rd_addr(ent_rd_addr),
    .rd_data(ent_rd_data),
    .wr_en  (ent_wr_en),
    .wr_addr(ent_wr_addr),
    .wr_data(ent_wr_data)
  );

  // --------------------------------------------------------------------------
  // Memory requests. Reads of the next chain entry go out in the same cycle
  // the current word is examined, so the walk runs one entry per cycle.
  // Writes to an entry never meet a read of it in the same cycle, and the
  // next request's first read comes only after the sequencer passes S_DONE and S_IDLE.
  // --------------------------------------------------------------------------
  always_comb begin
    head_rd_en   = 1'b0;
    head_wr_en   = 1'b0;
    head_wr_data = cur;
    ent_rd_en    = 1'b0;
    ent_rd_addr  = cur[AW-1:0];
    ent_wr_en    = 1'b0;
    ent_wr_addr  = cur[AW-1:0];
    ent_wr_data  = ent_rd_data;
    case (state)
      S_MOD: begin
        head_rd_en = mod_done &&
                     (op_q inside {cht_pkg::OP_INSERT, cht_pkg::OP_LOOKUP,
                                   cht_pkg::OP_REMOVE});
      end
      S_HEAD: begin
        if (!head_empty) begin
          ent_rd_en   = 1'b1;
          ent_rd_addr = head_rd_data[AW-1:0];
        end else if (op_q == cht_pkg::OP_INSERT && !pool_empty) begin
          // fetch the free entry's link to advance the pool
          ent_rd_en   = 1'b1;
          ent_rd_addr = free_head[AW-1:0];
        end
      end
      S_WALK: begin
        if (hit) begin
          if (op_q == cht_pkg::OP_INSERT) begin
            ent_wr_en   = 1'b1;
            ent_wr_data = {ent_key, val_q, ent_link};
          end else if (op_q == cht_pkg::OP_REMOVE) begin
            // removed entry goes on top of the free stack
            ent_wr_en   = 1'b1;
            ent_wr_data = {ent_key, ent_val, free_head};
          end
        end else if (!link_end) begin
          ent_rd_en   = 1'b1;
          ent_rd_addr = ent_link[AW-1:0];
        end else if (op_q == cht_pkg::OP_INSERT && !pool_empty) begin
          ent_rd_en   = 1'b1;
          ent_rd_addr = free_head[AW-1:0];
        end
      end
      S_ALLOC: begin
        ent_wr_en   = 1'b1;
        ent_wr_addr = free_head[AW-1:0];
        ent_wr_data = {key_q, val_q, NIL};
      end
      S_LINK: begin
        // point the predecessor (or the bucket head) at cur: the new tail
        // on an append, the removed entry's successor on a remove
        if (prev < NIL) begin
          ent_wr_en   = 1'b1;
          ent_wr_addr = prev[AW-1:0];
          ent_wr_data = {prev_key, prev_val, cur};
        end else begin
          head_wr_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and response register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      free_head <= '0;
      fill      <= '0;
    end else begin
      // S_DONE reloads the register itself when it frees up
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q      <= req.operation;
            key_q     <= req.key;
            val_q     <= req.value;
            res_value <= '0;
            state     <= S_MOD;
          end
        end

        S_MOD: begin
          if (mod_done) begin
            bucket <= mod_bucket;
            prev   <= NIL;
            if (op_q inside {cht_pkg::OP_INSERT, cht_pkg::OP_LOOKUP,
                             cht_pkg::OP_REMOVE}) begin
              state <= S_HEAD;
            end else begin
              // unused operation code: no change, answer not found
              res_status <= cht_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end
        end

        S_HEAD: begin
          if (!head_empty) begin
            cur   <= head_rd_data;
            state <= S_WALK;
          end
        end

        S_WALK: begin
          if (hit) begin
            case (op_q)
              cht_pkg::OP_LOOKUP: begin
                res_status <= cht_pkg::ST_FOUND;
                res_value  <= ent_val;
                state      <= S_DONE;
              end
              cht_pkg::OP_INSERT: begin
                res_status <= cht_pkg::ST_UPDATED;
                state      <= S_DONE;
              end
              cht_pkg::OP_REMOVE: begin
                res_status <= cht_pkg::ST_REMOVED;
                cur        <= ent_link;
                free_head  <= cur;
                state      <= S_LINK;
              end
              default: begin
                res_status <= cht_pkg::ST_NOT_FOUND;
                state      <= S_DONE;
              end
            endcase
          end else begin
            prev     <= cur;
            prev_key <= ent_key;
            prev_val <= ent_val;
            if (!link_end) begin
              cur <= ent_link;
            end
          end
        end

        S_ALLOC: begin
          // ent_rd_data holds the free entry; its link is only meaningful
          // once the entry has been handed out before
          cur <= free_head;
          if (free_head < fill) begin
            free_head <= ent_link;
          end else begin
            free_head <= free_head + IW'(1);
          end
          if (free_head == fill) begin
            fill <= fill + IW'(1);
          end
          res_status <= cht_pkg::ST_ADDED;
          state      <= S_LINK;
        end

        S_LINK: begin
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_value  <= res_value;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // key absent from its bucket
      if (miss_now) begin
        if (op_q == cht_pkg::OP_INSERT) begin
          if (pool_empty) begin
            res_status <= cht_pkg::ST_NO_ROOM;
            state      <= S_DONE;
          end else begin
            state <= S_ALLOC;
          end
        end else begin
          res_status <= cht_pkg::ST_NOT_FOUND;
          state      <= S_DONE;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // the modulo result only ever lands while the sequencer waits for it
  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("modulo done outside of S_MOD");

  // the free stack top is a recycled entry, the fill mark, or null at full
  a_free_head_fill: assert property (@(posedge clk) disable iff (rst)
    free_head <= fill)
    else $error("free_head beyond fill mark");

  // a response appears only when the sequencer hands one over
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("response without completion");

  // the sequencer leaves idle only on an accepted request
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !req.valid) |=> (state == S_IDLE))
    else $error("left idle without a request");

endmodule

// ===== verif/tb_chained_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_table: self-checking bench for the chained hash table
// Drives insert, lookup, remove and the unused opcode over valid/ready, keeps
// its own copy of the buckets, chains and free pool to predict every response,
// and compares each response field by field under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_chained_hash_table;

  localparam int BUCKETS     = cht_pkg::BUCKET_COUNT_DEF;
  localparam int ENTRIES     = cht_pkg::ENTRY_COUNT_DEF;
  localparam int NIL         = ENTRIES;        // null chain index
  localparam int KEY_POOL_SZ = 96;             // more keys than entries, so the pool runs dry
  localparam int PHASE_ITEMS = 240;
  localparam int STALL_LIMIT = 5000;           // cycles without any handshake
  localparam int DRAIN_CYCLES = 120;           // outlasts a request that walks all 64 entries

  // The opcode field is 2 bits wide but only three codes are defined.
  localparam logic [cht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [cht_pkg::STATUS_W-1:0] status;
    logic [cht_pkg::VALUE_W-1:0]  found_value;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cht_req_if req_if();
  cht_rsp_if rsp_if();

  chained_hash_table DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow copy of the table: bucket heads, entry pool and free list.
  // --------------------------------------------------------------------------
  int                          bucket_head [BUCKETS];
  logic [cht_pkg::KEY_W-1:0]   entry_key   [ENTRIES];
  logic [cht_pkg::VALUE_W-1:0] entry_value [ENTRIES];
  int                          entry_link  [ENTRIES];
  int                          free_head;

  answer_t pending_answers[$];   // responses still owed by the DUT, oldest first

  int src_idle_pct  = 0;         // percent of cycles the requester holds off
  int snk_stall_pct = 0;         // percent of cycles the response side stalls
  int mismatch_count = 0;
  int request_count  = 0;
  int response_count = 0;
  int status_tally [6];
  int quiet_cycles   = 0;
  logic [cht_pkg::KEY_W-1:0] key_pool [KEY_POOL_SZ];

  // Walk the chain of a bucket looking for k. prev is the predecessor of the
  // hit (NIL at the head); tail is the last entry when the key is absent.
  function automatic int chain_search(input int bkt, input logic [cht_pkg::KEY_W-1:0] k,
                                      output int prev, output int tail);
    int cur;
    int steps;
    cur   = bucket_head[bkt];
    prev  = NIL;
    steps = 0;
    while (cur < ENTRIES && steps < ENTRIES) begin
      if (entry_key[cur] == k) begin
        tail = NIL;
        return cur;
      end
      prev = cur;
      cur  = entry_link[cur];
      steps++;
    end
    tail = prev;
    return NIL;
  endfunction

  // Apply one request to the shadow table and return the response it owes.
  function automatic answer_t apply_request(input logic [cht_pkg::OP_W-1:0] op,
                                            input logic [cht_pkg::KEY_W-1:0] k,
                                            input logic [cht_pkg::VALUE_W-1:0] v);
    answer_t ans;
    int bkt;
    int hit;
    int prev;
    int tail;
    int fresh;
    ans.status      = cht_pkg::ST_NOT_FOUND;
    ans.found_value = '0;
    bkt = int'(k % BUCKETS);
    case (op)
      cht_pkg::OP_INSERT: begin
        hit = chain_search(bkt, k, prev, tail);
        if (hit < ENTRIES) begin
          entry_value[hit] = v;
          ans.status = cht_pkg::ST_UPDATED;
        end else if (free_head >= ENTRIES) begin
          ans.status = cht_pkg::ST_NO_ROOM;
        end else begin
          fresh              = free_head;
          free_head          = entry_link[fresh];
          entry_key[fresh]   = k;
          entry_value[fresh] = v;
          entry_link[fresh]  = NIL;
          if (tail < ENTRIES) entry_link[tail] = fresh;
          else bucket_head[bkt] = fresh;
          ans.status = cht_pkg::ST_ADDED;
        end
      end
      cht_pkg::OP_LOOKUP: begin
        hit = chain_search(bkt, k, prev, tail);
        if (hit < ENTRIES) begin
          ans.status      = cht_pkg::ST_FOUND;
          ans.found_value = entry_value[hit];
        end
      end
      cht_pkg::OP_REMOVE: begin
        hit = chain_search(bkt, k, prev, tail);
        if (hit < ENTRIES) begin
          if (prev < ENTRIES) entry_link[prev] = entry_link[hit];
          else bucket_head[bkt] = entry_link[hit];
          entry_link[hit] = free_head;
          free_head       = hit;
          ans.status      = cht_pkg::ST_REMOVED;
        end
      end
      default: begin
        // unused opcode: no state change, answers not found
      end
    endcase
    return ans;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: optional idle cycles, then hold valid until accepted.
  // Called and returns on a falling edge; valid stays high for back-to-back.
  // --------------------------------------------------------------------------
  task automatic issue_request(input logic [cht_pkg::OP_W-1:0] op,
                               input logic [cht_pkg::KEY_W-1:0] k,
                               input logic [cht_pkg::VALUE_W-1:0] v);
    answer_t ans;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      req_if.key   = $urandom;      // junk payload while idle
      @(negedge clk);
    end
    req_if.valid     = 1'b1;
    req_if.operation = op;
    req_if.key       = k;
    req_if.value     = v;
    do @(posedge clk); while (!req_if.ready);
    ans = apply_request(op, k, v);
    pending_answers.push_back(ans);
    status_tally[ans.status]++;
    request_count++;
    @(negedge clk);
  endtask

  // Response side: random stalls, driven on the falling edge.
  always @(negedge clk) begin
    if (rst) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Response checker: each accepted response against the oldest expectation.
  always @(posedge clk) begin
    answer_t exp_ans;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      response_count++;
      if (pending_answers.size() == 0) begin
        $error("unexpected response: status %0d found_value 0x%08h",
               rsp_if.status, rsp_if.found_value);
        mismatch_count++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (rsp_if.status !== exp_ans.status) begin
          $error("status: expected %0d, actual %0d", exp_ans.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.found_value !== exp_ans.found_value) begin
          $error("found_value: expected 0x%08h, actual 0x%08h",
                 exp_ans.found_value, rsp_if.found_value);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d responses owed",
                 STALL_LIMIT, pending_answers.size());
        $display("chained_hash_table test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [cht_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly keys from the shared pool so hits, updates and removes happen;
  // some fresh random keys for misses.
  function automatic logic [cht_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL_SZ-1)];
    return $urandom;
  endfunction

  function automatic logic [cht_pkg::OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) return cht_pkg::OP_INSERT;
    if (r < 70) return cht_pkg::OP_LOOKUP;
    if (r < 95) return cht_pkg::OP_REMOVE;
    return OP_UNUSED;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every operation, key/value extremes, chain head/middle/tail cases,
  // remove of an absent key and the unused opcode.
  task automatic test_basic_operations();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    issue_request(cht_pkg::OP_LOOKUP, 32'h0, $urandom);          // empty table
    issue_request(cht_pkg::OP_REMOVE, 32'h0, $urandom);          // remove from empty
    issue_request(cht_pkg::OP_INSERT, 32'h0, 32'h0);
    issue_request(cht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(cht_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    issue_request(cht_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF);     // overwrite
    issue_request(cht_pkg::OP_LOOKUP, 32'h0, $urandom);
    // keys 20, 40, 60 share bucket 0 with key 0: four-deep chain
    issue_request(cht_pkg::OP_INSERT, 32'd20, 32'h1234_5678);
    issue_request(cht_pkg::OP_INSERT, 32'd40, 32'h8765_4321);
    issue_request(cht_pkg::OP_INSERT, 32'd60, 32'hDEAD_BEEF);
    issue_request(cht_pkg::OP_LOOKUP, 32'd60, 32'h0);            // tail of chain
    issue_request(cht_pkg::OP_REMOVE, 32'd20, 32'h0);            // middle of chain
    issue_request(cht_pkg::OP_LOOKUP, 32'd20, 32'h0);
    issue_request(cht_pkg::OP_LOOKUP, 32'd40, 32'h0);
    issue_request(cht_pkg::OP_REMOVE, 32'h0, 32'h0);             // head of chain
    issue_request(cht_pkg::OP_LOOKUP, 32'd60, 32'h0);
    issue_request(cht_pkg::OP_REMOVE, 32'd60, 32'h0);            // tail of chain
    issue_request(cht_pkg::OP_REMOVE, 32'd60, 32'h0);            // now absent
    issue_request(OP_UNUSED, 32'd40, 32'hFFFF_FFFF);             // must not touch key 40
    issue_request(cht_pkg::OP_LOOKUP, 32'd40, 32'h0);
    issue_request(cht_pkg::OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    issue_request(cht_pkg::OP_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
    issue_request(cht_pkg::OP_INSERT, 32'd20, 32'h5A5A_5A5A);    // reuses a freed entry
    issue_request(cht_pkg::OP_LOOKUP, 32'd20, 32'h0);
  endtask

  // Fill the pool past capacity so inserts get no room, probe, then drain it.
  task automatic test_pool_exhaustion();
    logic [cht_pkg::KEY_W-1:0] stored_keys[$];
    logic [cht_pkg::KEY_W-1:0] k;
    src_idle_pct  = 0;
    snk_stall_pct = 53;
    repeat (ENTRIES + 8) begin
      k = $urandom;
      stored_keys.push_back(k);
      issue_request(cht_pkg::OP_INSERT, k, pick_value());
    end
    repeat (10) issue_request(cht_pkg::OP_LOOKUP,
                              stored_keys[$urandom_range(stored_keys.size()-1)],
                              $urandom);
    stored_keys.shuffle();
    foreach (stored_keys[i]) issue_request(cht_pkg::OP_REMOVE, stored_keys[i], $urandom);
    repeat (8) issue_request(cht_pkg::OP_INSERT, $urandom, pick_value());
  endtask

  // Mixed traffic over a key pool, half of it crowded into buckets 0..3, once per
  // idle/stall mix.
  task automatic test_random_traffic();
    int src_mix [4] = '{0, 53, 0, 16};
    int snk_mix [4] = '{0, 0, 53, 16};
    logic [cht_pkg::KEY_W-1:0] k;
    foreach (key_pool[i]) begin
      k = $urandom;
      // half the pool lands in buckets 0..3 to build long chains
      if (i % 2 == 0) k = k - (k % BUCKETS) + $urandom_range(3);
      key_pool[i] = k;
    end
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = src_mix[p];
      snk_stall_pct = snk_mix[p];
      repeat (PHASE_ITEMS) issue_request(pick_op(), pick_key(), pick_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    req_if.valid     = 1'b0;
    req_if.operation = cht_pkg::OP_INSERT;
    req_if.key       = '0;
    req_if.value     = '0;
    rsp_if.ready     = 1'b0;
    foreach (bucket_head[i]) bucket_head[i] = NIL;
    foreach (entry_link[i]) begin
      entry_key[i]   = '0;
      entry_value[i] = '0;
      entry_link[i]  = i + 1;
    end
    free_head = 0;
    foreach (status_tally[i]) status_tally[i] = 0;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_basic_operations();
    test_pool_exhaustion();
    test_random_traffic();
    req_if.valid = 1'b0;

    // let every owed response come back, then watch for strays
    snk_stall_pct = 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests / %0d responses: %0d added, %0d updated, %0d no room,",
             request_count, response_count, status_tally[cht_pkg::ST_ADDED],
             status_tally[cht_pkg::ST_UPDATED], status_tally[cht_pkg::ST_NO_ROOM]);
    $display("  %0d found, %0d not found, %0d removed, across four idle/stall mixes",
             status_tally[cht_pkg::ST_FOUND], status_tally[cht_pkg::ST_NOT_FOUND],
             status_tally[cht_pkg::ST_REMOVED]);
    if (mismatch_count == 0) begin
      $display("chained_hash_table test passed");
    end else begin
      $display("chained_hash_table test failed");
    end
    $finish;
  end

endmodule
